@@ rtl/pidc_pkg.sv @@
// pidc_pkg: widths, register indexes, mode bits, sequencer codes and helpers
// shared by the pid controller modules; depends on nothing
`timescale 1ns / 1ps
package pidc_pkg;

	localparam int OPW  = 33;
	localparam int PRW  = 2 * OPW;
	localparam int STW  = 5;
	localparam int CIW  = 3;

	localparam logic [CIW-1:0] REG_PROP   = 3'd0;
	localparam logic [CIW-1:0] REG_IGAIN  = 3'd1;
	localparam logic [CIW-1:0] REG_DGAIN  = 3'd2;
	localparam logic [CIW-1:0] REG_OLIMIT = 3'd3;
	localparam logic [CIW-1:0] REG_DBAND  = 3'd4;
	localparam logic [CIW-1:0] REG_ILIMIT = 3'd5;
	localparam logic [CIW-1:0] REG_MODE   = 3'd6;

	localparam int M_TRAP   = 0;
	localparam int M_VRATE  = 1;
	localparam int M_DMEAS  = 2;
	localparam int M_DFILT  = 3;
	localparam int M_ILIM   = 4;
	localparam int M_OFILT  = 5;

	localparam logic [STW-1:0] S_IDLE = 5'd0;
	localparam logic [STW-1:0] S_ERR  = 5'd1;
	localparam logic [STW-1:0] S_MD   = 5'd2;
	localparam logic [STW-1:0] S_MI   = 5'd3;
	localparam logic [STW-1:0] S_MP   = 5'd4;
	localparam logic [STW-1:0] S_CP   = 5'd5;
	localparam logic [STW-1:0] S_MR   = 5'd6;
	localparam logic [STW-1:0] S_CR   = 5'd7;
	localparam logic [STW-1:0] S_FIX  = 5'd8;
	localparam logic [STW-1:0] S_F1   = 5'd9;
	localparam logic [STW-1:0] S_F2   = 5'd10;
	localparam logic [STW-1:0] S_CF   = 5'd11;
	localparam logic [STW-1:0] S_SUM  = 5'd12;
	localparam logic [STW-1:0] S_DRV  = 5'd13;
	localparam logic [STW-1:0] S_O1   = 5'd14;
	localparam logic [STW-1:0] S_O2   = 5'd15;
	localparam logic [STW-1:0] S_O3   = 5'd16;
	localparam logic [STW-1:0] S_CO   = 5'd17;
	localparam logic [STW-1:0] S_LIM  = 5'd18;
	localparam logic [STW-1:0] S_OUT  = 5'd19;
	localparam logic [STW-1:0] S_Q1   = 5'd20;
	localparam logic [STW-1:0] S_Q2   = 5'd21;
	localparam logic [STW-1:0] S_Q3   = 5'd22;
	localparam logic [STW-1:0] S_Q4   = 5'd23;

	typedef logic signed [OPW-1:0] op_t;
	typedef logic signed [PRW-1:0] prod_t;

	// saturate a wide signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [PRW-1:0] v);
		logic signed [31:0] r;
		if (v > prod_t'(64'sh7fffffff)) r = 32'sh7fffffff;
		else if (v < -prod_t'(64'sh80000000)) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction

endpackage

@@ rtl/pidc_mul.sv @@
// pidc_mul: shared signed multiplier with registered product
// depends on pidc_pkg
`timescale 1ns / 1ps
module pidc_mul (
	input  logic           clk,
	input  pidc_pkg::op_t  a,
	input  pidc_pkg::op_t  b,
	output pidc_pkg::prod_t prod
);

	pidc_pkg::prod_t prod_q;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	assign prod = prod_q;

endmodule

@@ rtl/pid_controller_with_options.sv @@
// pid_controller_with_options: pid controller sequenced around one multiplier
// depends on pidc_pkg and pidc_mul
//
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  measured_value, target_value
// m_*       out  m_tvalid/m_tready  drive_value
// cfg_*     in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// one item is in flight at a time: the sequencer forms the error, then the derivative,
// integral and proportional products, then sums and limits the drive; the derivative
// and output filters add steps, and variable rate scales the integral term (reciprocal
// multiply, then one to four compare-subtract steps); a dead-band item goes straight
// to the output. the single multiplier sets this sequence; reset clears the state,
// output valid, config and history registers; a held result stalls the next commit
`timescale 1ns / 1ps
module pid_controller_with_options #(
	parameter longint RATE_BAND_A         = 655360,
	parameter longint RATE_BAND_B         = 0,
	parameter longint DERIV_FILTER_ALPHA  = 32768,
	parameter longint OUTPUT_FILTER_ALPHA = 32768
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // [31:0] measured_value, [63:32] target_value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [31:0] drive_value
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam longint DAL = (DERIV_FILTER_ALPHA < 0) ? 0 :
		((DERIV_FILTER_ALPHA > 65536) ? 65536 : DERIV_FILTER_ALPHA);
	localparam longint OAL = (OUTPUT_FILTER_ALPHA < 0) ? 0 :
		((OUTPUT_FILTER_ALPHA > 65536) ? 65536 : OUTPUT_FILTER_ALPHA);
	localparam logic [16:0] DA   = 17'(DAL);
	localparam logic [16:0] DA_N = 17'(65536 - DAL);
	localparam logic [16:0] OA   = 17'(OAL);
	localparam logic [16:0] OA_N = 17'(65536 - OAL);
	localparam logic [31:0] RA   = 32'(RATE_BAND_A);
	localparam logic [31:0] RB   = 32'(RATE_BAND_B);
	localparam logic [32:0] RAB  = 33'(RATE_BAND_A + RATE_BAND_B);
	// reciprocal of the rate band, scaled so the estimate never exceeds the quotient
	localparam int RA_BITS = $clog2(RATE_BAND_A + 1);
	localparam int RA_SH   = RA_BITS - 1;
	localparam logic [31:0] RA_RCP = 32'(((64'sd1 <<< (RA_BITS + 31)) - 1) / RATE_BAND_A);

	logic signed [31:0] prop_q, igain_q, dgain_q;
	logic [30:0] olim_q, dband_q, ilim_q;
	logic [5:0]  mode_q;

	logic signed [31:0] pmeas_q, perr_q, pout_q, pderiv_q, integ_q;

	logic [pidc_pkg::STW-1:0] state_q;
	logic signed [31:0] meas_q, targ_q, err_q, dterm_q, iterm_q, isum_q, res_q;
	logic [31:0] aerr_q;
	logic signed [41:0] pterm_q;
	logic signed [47:0] drive_q;
	pidc_pkg::prod_t acc_q;
	logic db_q;
	logic [61:0] num_q;
	logic [32:0] rem_q;
	logic [31:0] quo_q;
	logic        neg_q;
	logic        m_valid_q;
	logic [31:0] m_data_q;

	pidc_pkg::op_t   op_a, op_b;
	pidc_pkg::prod_t prod;

	logic signed [32:0] diff_c, tsum_c;
	logic signed [31:0] err_c;
	logic [31:0] aerr_c;
	pidc_pkg::prod_t rnd24_c, rnd25_c, rnd16_c, mag_c, acc_c;
	logic signed [32:0] isum_c;
	logic signed [31:0] isat_c;
	logic signed [47:0] olim_c;
	logic        next_f;
	logic        out_load_c;

	pidc_mul u_mul (
		.clk  (clk),
		.a    (op_a),
		.b    (op_b),
		.prod (prod)
	);

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == pidc_pkg::S_IDLE);
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = m_data_q;
	assign out_load_c = (state_q == pidc_pkg::S_OUT) && (!m_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_q  <= '0;
			igain_q <= '0;
			dgain_q <= '0;
			olim_q  <= '0;
			dband_q <= '0;
			ilim_q  <= '0;
			mode_q  <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				pidc_pkg::REG_PROP:   prop_q  <= cfg_data;
				pidc_pkg::REG_IGAIN:  igain_q <= cfg_data;
				pidc_pkg::REG_DGAIN:  dgain_q <= cfg_data;
				pidc_pkg::REG_OLIMIT: olim_q  <= cfg_data[30:0];
				pidc_pkg::REG_DBAND:  dband_q <= cfg_data[30:0];
				pidc_pkg::REG_ILIMIT: ilim_q  <= cfg_data[30:0];
				pidc_pkg::REG_MODE:   mode_q  <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		diff_c = 33'(targ_q) - 33'(meas_q);
		err_c  = pidc_pkg::sat32(pidc_pkg::PRW'(diff_c));
		aerr_c = err_c[31] ? 32'(-err_c) : 32'(err_c);
		tsum_c = 33'(err_q) + 33'(perr_q);
		if (tsum_c == 33'sh100000000) tsum_c = 33'sh100000001;
		rnd24_c = (prod + (pidc_pkg::PRW'(1) <<< 23)) >>> 24;
		rnd25_c = (prod + (pidc_pkg::PRW'(1) <<< 24)) >>> 25;
		acc_c   = acc_q + prod;
		rnd16_c = (acc_c + (pidc_pkg::PRW'(1) <<< 15)) >>> 16;
		mag_c   = prod[pidc_pkg::PRW-1] ? -prod : prod;
		isum_c  = 33'(integ_q) + 33'(iterm_q);
		isat_c  = pidc_pkg::sat32(pidc_pkg::PRW'(isum_c));
		if (mode_q[pidc_pkg::M_ILIM]) begin
			if (33'(isat_c) > $signed({2'b0, ilim_q})) isat_c = $signed({1'b0, ilim_q});
			else if (33'(isat_c) < -$signed({2'b0, ilim_q}))
				isat_c = 32'(-$signed({2'b0, ilim_q}));
		end
		olim_c = $signed({17'b0, olim_q});
		next_f = mode_q[pidc_pkg::M_DFILT];
	end

	// operand select for the shared multiplier
	always_comb begin
		op_a = '0;
		op_b = '0;
		case (state_q)
			pidc_pkg::S_MD: begin
				op_a = 33'(dgain_q);
				op_b = mode_q[pidc_pkg::M_DMEAS] ? 33'(pmeas_q) - 33'(meas_q)
				                                 : 33'(err_q) - 33'(perr_q);
			end
			pidc_pkg::S_MI: begin
				op_a = 33'(igain_q);
				op_b = mode_q[pidc_pkg::M_TRAP] ? tsum_c : 33'(err_q);
			end
			pidc_pkg::S_MP: begin
				op_a = 33'(prop_q);
				op_b = 33'(err_q);
			end
			pidc_pkg::S_MR: begin
				op_a = 33'(iterm_q);
				op_b = $signed({1'b0, 32'(RAB - {1'b0, aerr_q})});
			end
			pidc_pkg::S_Q1: begin
				op_a = $signed({1'b0, 32'(num_q >> RA_SH)});
				op_b = $signed({1'b0, RA_RCP});
			end
			pidc_pkg::S_Q3: begin
				op_a = $signed({1'b0, quo_q});
				op_b = $signed({1'b0, RA});
			end
			pidc_pkg::S_F1: begin
				op_a = 33'(dterm_q);
				op_b = $signed({16'b0, DA_N});
			end
			pidc_pkg::S_F2: begin
				op_a = 33'(pderiv_q);
				op_b = $signed({16'b0, DA});
			end
			pidc_pkg::S_O1: begin
				op_a = $signed({17'b0, drive_q[15:0]});
				op_b = $signed({16'b0, OA_N});
			end
			pidc_pkg::S_O2: begin
				op_a = 33'($signed(drive_q[47:16]));
				op_b = $signed({16'b0, OA_N});
			end
			pidc_pkg::S_O3: begin
				op_a = 33'(pout_q);
				op_b = $signed({16'b0, OA});
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= pidc_pkg::S_IDLE;
			m_valid_q <= 1'b0;
			pmeas_q   <= '0;
			perr_q    <= '0;
			pout_q    <= '0;
			pderiv_q  <= '0;
			integ_q   <= '0;
		end else begin
			if (m_valid_q && m_tready && !out_load_c) m_valid_q <= 1'b0;
			case (state_q)
				pidc_pkg::S_IDLE: begin
					if (s_tvalid) begin
						meas_q  <= s_tdata[31:0];
						targ_q  <= s_tdata[63:32];
						state_q <= pidc_pkg::S_ERR;
					end
				end
				pidc_pkg::S_ERR: begin
					err_q  <= err_c;
					aerr_q <= aerr_c;
					db_q   <= aerr_c <= {1'b0, dband_q};
					res_q  <= '0;
					state_q <= (aerr_c <= {1'b0, dband_q}) ? pidc_pkg::S_OUT : pidc_pkg::S_MD;
				end
				pidc_pkg::S_MD: state_q <= pidc_pkg::S_MI;
				pidc_pkg::S_MI: begin
					dterm_q <= pidc_pkg::sat32(rnd24_c);
					state_q <= pidc_pkg::S_MP;
				end
				pidc_pkg::S_MP: begin
					iterm_q <= pidc_pkg::sat32(mode_q[pidc_pkg::M_TRAP] ? rnd25_c : rnd24_c);
					state_q <= pidc_pkg::S_CP;
				end
				pidc_pkg::S_CP: begin
					pterm_q <= rnd24_c[41:0];
					if (mode_q[pidc_pkg::M_VRATE] && ({1'b0, aerr_q} >= RAB)) begin
						iterm_q <= '0;
						state_q <= next_f ? pidc_pkg::S_F1 : pidc_pkg::S_SUM;
					end else if (mode_q[pidc_pkg::M_VRATE] && (aerr_q > RB)) begin
						state_q <= pidc_pkg::S_MR;
					end else begin
						state_q <= next_f ? pidc_pkg::S_F1 : pidc_pkg::S_SUM;
					end
				end
				pidc_pkg::S_MR: state_q <= pidc_pkg::S_CR;
				pidc_pkg::S_CR: begin
					// magnitude is below the band times 2^31, so the quotient fits 31 bits
					neg_q   <= prod[pidc_pkg::PRW-1];
					num_q   <= mag_c[61:0];
					state_q <= pidc_pkg::S_Q1;
				end
				pidc_pkg::S_Q1: state_q <= pidc_pkg::S_Q2;
				pidc_pkg::S_Q2: begin
					// estimate is at most three below the true quotient
					quo_q   <= prod[63:32];
					state_q <= pidc_pkg::S_Q3;
				end
				pidc_pkg::S_Q3: state_q <= pidc_pkg::S_Q4;
				pidc_pkg::S_Q4: begin
					rem_q   <= 33'(num_q - prod[61:0]);
					state_q <= pidc_pkg::S_FIX;
				end
				pidc_pkg::S_FIX: begin
					if (rem_q >= {1'b0, RA}) begin
						rem_q <= rem_q - {1'b0, RA};
						quo_q <= quo_q + 32'd1;
					end else begin
						iterm_q <= neg_q ? -$signed(quo_q) : $signed(quo_q);
						state_q <= next_f ? pidc_pkg::S_F1 : pidc_pkg::S_SUM;
					end
				end
				pidc_pkg::S_F1: state_q <= pidc_pkg::S_F2;
				pidc_pkg::S_F2: begin
					acc_q   <= prod;
					state_q <= pidc_pkg::S_CF;
				end
				pidc_pkg::S_CF: begin
					dterm_q <= pidc_pkg::sat32(rnd16_c);
					state_q <= pidc_pkg::S_SUM;
				end
				pidc_pkg::S_SUM: begin
					isum_q  <= isat_c;
					state_q <= pidc_pkg::S_DRV;
				end
				pidc_pkg::S_DRV: begin
					drive_q <= 48'(pterm_q) + 48'(isum_q) + 48'(dterm_q);
					state_q <= mode_q[pidc_pkg::M_OFILT] ? pidc_pkg::S_O1 : pidc_pkg::S_LIM;
				end
				pidc_pkg::S_O1: state_q <= pidc_pkg::S_O2;
				pidc_pkg::S_O2: begin
					acc_q   <= prod;
					state_q <= pidc_pkg::S_O3;
				end
				pidc_pkg::S_O3: begin
					acc_q   <= acc_q + (prod <<< 16);
					state_q <= pidc_pkg::S_CO;
				end
				pidc_pkg::S_CO: begin
					drive_q <= rnd16_c[47:0];
					state_q <= pidc_pkg::S_LIM;
				end
				pidc_pkg::S_LIM: begin
					if (drive_q > olim_c) res_q <= 32'(olim_c);
					else if (drive_q < -olim_c) res_q <= 32'(-olim_c);
					else res_q <= drive_q[31:0];
					state_q <= pidc_pkg::S_OUT;
				end
				pidc_pkg::S_OUT: begin
					if (out_load_c) begin
						m_valid_q <= 1'b1;
						m_data_q  <= res_q;
						pmeas_q   <= meas_q;
						perr_q    <= err_q;
						pout_q    <= res_q;
						if (!db_q) begin
							integ_q  <= isum_q;
							pderiv_q <= dterm_q;
						end
						state_q <= pidc_pkg::S_IDLE;
					end
				end
				default: state_q <= pidc_pkg::S_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/pidc_checker.sv @@
// pidc_checker: port-level checks on the pid controller, bound to the top
// depends on pid_controller_with_options
`timescale 1ns / 1ps
module pidc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	// busy after taking an item
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken while busy");

	// a result never shows up the cycle after an item is taken
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !$rose(m_tvalid))
		else $error("result too early");

	// ready returns only after the result was loaded
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		(!s_tready ##1 s_tready) |-> m_tvalid)
		else $error("ready without a result");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result changed");

endmodule

bind pid_controller_with_options pidc_checker u_pidc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
